// ===== design/drbq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drbq_pkg
// Types and codes shared by the event queue modules.
// ----------------------------------------------------------------------------
package drbq_pkg;

  localparam logic [2:0] OP_ENQ      = 3'd0;
  localparam logic [2:0] OP_BEGIN    = 3'd1;
  localparam logic [2:0] OP_COMPLETE = 3'd2;
  localparam logic [2:0] OP_RESET    = 3'd3;
  localparam logic [2:0] OP_SETCAP   = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSLOT  = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] payload;
    logic [15:0] amount;
    logic        remove_reserved;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_id_high;
    logic [63:0] out_id_low;
    logic [63:0] out_payload;
    logic        last_of_run;
    logic [31:0] dropped_count;
    logic [4:0]  entry_count;
    logic        batch_in_flight;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/dedup_retry_batch_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_retry_batch_queue
// Bounded drop-oldest event table with one in-flight batch reservation.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data. One item is handled at a time; in_ready is
// low from acceptance until its last result has been taken.
// The table sits in a memory with one read port, so every walk over it
// handles one entry at a time (read, then compare or move) through a single
// compare/move unit:
//   enqueue: a duplicate search over the held entries, then an eviction
//   shift when the table is at capacity;
//   begin batch: one read and one result per emitted entry;
//   complete batch: a compaction pass over the held entries when removing;
//   set capacity: up to one eviction for each entry above the new capacity.
// A stalled receiver simply holds the result register and the sequencer
// waits. Synchronous reset empties the table, clears the reservation and
// the drop counter and sets the capacity to DEPTH; no clearing pass runs
// since unheld slots are never read.
// ----------------------------------------------------------------------------
module dedup_retry_batch_queue #(
  parameter int DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  drbq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output drbq_pkg::out_item_t out_data
);
  import drbq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DUPRD  = 4'd1;
  localparam logic [3:0] S_DUPCK  = 4'd2;
  localparam logic [3:0] S_EVSCAN = 4'd3;
  localparam logic [3:0] S_SHRD   = 4'd4;
  localparam logic [3:0] S_SHWR   = 4'd5;
  localparam logic [3:0] S_APPEND = 4'd6;
  localparam logic [3:0] S_EMRD   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_CPRD   = 4'd9;
  localparam logic [3:0] S_CPWR   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_CAPCK  = 4'd12;

  logic [191:0]     mem [DEPTH];
  logic [DEPTH-1:0] rsv;
  logic [191:0]     rd;
  logic [3:0]       state;
  in_item_t         cur;
  logic [CW-1:0]    held, cap, idx, wp, lim;
  logic [31:0]      drops;
  logic             active;
  logic             evict_mode;  // eviction run for set capacity
  out_item_t        res;

  logic [CW-1:0] first_free;
  logic          none_free;
  // Priority search over the reservation flags, which are flip-flops.
  always_comb begin
    first_free = DEPTH_C;
    none_free  = 1'b1;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!rsv[k] && CW'(k) < held) begin
        first_free = CW'(k);
        none_free  = 1'b0;
      end
    end
  end

  logic [31:0] drops_inc;
  assign drops_inc = (drops == 32'hFFFF_FFFF) ? drops : drops + 32'd1;

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    rd <= mem[idx[AW-1:0]];
    if (state == S_SHWR) mem[AW'(idx - CW'(1))] <= rd;
    if (state == S_CPWR && !rsv[idx[AW-1:0]]) mem[wp[AW-1:0]] <= rd;
    if (state == S_APPEND) mem[held[AW-1:0]] <= {cur.id_high, cur.id_low, cur.payload};
  end

  task automatic post(input logic [2:0] st, input logic [191:0] d, input logic lst,
                      input logic [31:0] dc, input logic [CW-1:0] hc, input logic ba);
    res.status          <= st;
    res.out_id_high     <= d[191:128];
    res.out_id_low      <= d[127:64];
    res.out_payload     <= d[63:0];
    res.last_of_run     <= lst;
    res.dropped_count   <= dc;
    res.entry_count     <= 5'(hc);
    res.batch_in_flight <= ba;
    out_valid           <= 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; rsv <= '0; held <= '0;
      cap <= DEPTH_C; drops <= '0; active <= 1'b0; idx <= '0; wp <= '0;
      lim <= '0; evict_mode <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          cur <= in_data;
          idx <= '0;
          unique case (in_data.op)
            OP_ENQ: begin
              if (in_data.id_high == '0 && in_data.id_low == '0) begin
                drops <= drops_inc;
                post(ST_INVALID, '0, 1'b1, drops_inc, held, active);
              end else state <= (held == '0) ? S_EVSCAN : S_DUPRD;
            end
            OP_BEGIN: begin
              if (active || in_data.amount == '0 || held == '0)
                post(ST_REFUSED, '0, 1'b1, drops, held, active);
              else begin
                lim <= ({16'd0, in_data.amount} < 32'(held)) ?
                       CW'(in_data.amount) : held;
                state <= S_EMRD;
              end
            end
            OP_COMPLETE: begin
              if (in_data.remove_reserved && active) begin
                wp <= '0; state <= S_CPRD;
              end else begin
                rsv <= '0; active <= 1'b0;
                post(ST_DONE, '0, 1'b1, drops, held, 1'b0);
              end
            end
            OP_RESET: begin
              held <= '0; rsv <= '0; active <= 1'b0; drops <= '0;
              post(ST_DONE, '0, 1'b1, '0, '0, 1'b0);
            end
            OP_SETCAP: begin
              if (in_data.amount == '0) cap <= CW'(1);
              else if ({16'd0, in_data.amount} > DEPTH) cap <= DEPTH_C;
              else cap <= CW'(in_data.amount);
              state <= S_CAPCK;
            end
            default: post(ST_INVALID, '0, 1'b1, drops, held, active);
          endcase
        end
        S_DUPRD: state <= S_DUPCK;
        S_DUPCK: begin
          if (rd[191:64] == {cur.id_high, cur.id_low}) begin
            drops <= drops_inc;
            post(ST_INVALID, '0, 1'b1, drops_inc, held, active);
            state <= S_OUT;
          end else if (idx + CW'(1) >= held) state <= S_EVSCAN;
          else begin
            idx <= idx + CW'(1); state <= S_DUPRD;
          end
        end
        S_EVSCAN: begin
          evict_mode <= 1'b0;
          if (held >= cap || held >= DEPTH_C) begin
            if (none_free) begin
              drops <= drops_inc;
              post(ST_NOSLOT, '0, 1'b1, drops_inc, held, active);
              state <= S_OUT;
            end else begin
              drops <= drops_inc;
              idx <= first_free + CW'(1);
              state <= S_SHRD;
            end
          end else state <= S_APPEND;
        end
        S_SHRD: begin
          if (idx >= held) begin
            held <= held - CW'(1);
            state <= evict_mode ? S_CAPCK : S_APPEND;
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          // Move one entry down by one slot together with its flag.
          rsv[AW'(idx - CW'(1))] <= rsv[idx[AW-1:0]];
          idx <= idx + CW'(1);
          state <= S_SHRD;
        end
        S_APPEND: begin
          rsv[held[AW-1:0]] <= 1'b0;
          held <= held + CW'(1);
          post(ST_OK, '0, 1'b1, drops, held + CW'(1), active);
          state <= S_OUT;
        end
        S_EMRD: if (!out_valid || out_ready) state <= S_EMIT;
        S_EMIT: begin
          rsv[idx[AW-1:0]] <= 1'b1;
          active <= 1'b1;
          post(ST_OK, rd, (idx + CW'(1) == lim), drops, held, 1'b1);
          if (idx + CW'(1) == lim) state <= S_OUT;
          else begin
            idx <= idx + CW'(1); state <= S_EMRD;
          end
        end
        S_CPRD: begin
          if (idx >= held) begin
            held <= wp; rsv <= '0; active <= 1'b0;
            post(ST_DONE, '0, 1'b1, drops, wp, 1'b0);
            state <= S_OUT;
          end else state <= S_CPWR;
        end
        S_CPWR: begin
          if (!rsv[idx[AW-1:0]]) wp <= wp + CW'(1);
          idx <= idx + CW'(1);
          state <= S_CPRD;
        end
        S_CAPCK: begin
          if (held > cap && !none_free) begin
            drops <= drops_inc;
            idx <= first_free + CW'(1);
            evict_mode <= 1'b1;
            state <= S_SHRD;
          end else begin
            post(ST_DONE, '0, 1'b1, drops, held, active);
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (rst) held <= DEPTH_C)
    else $error("held count above depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_drops_mono: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> drops >= $past(drops))
    else $error("drop counter fell during an item");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_dedup_retry_batch_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_dedup_retry_batch_queue
// Self-checking bench for the event queue. A directed table covers resets,
// zero and duplicate ids, eviction, batches and capacity limits. Random
// sequences follow. Every result is checked against a behavioural copy of
// the queue kept inside the bench.
// ----------------------------------------------------------------------------
module tb_dedup_retry_batch_queue;
  import drbq_pkg::*;

  localparam int DEPTH = 16;
  localparam int N_DIRECTED = 22;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  dedup_retry_batch_queue #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // Shadow copy of the event table.
  logic [63:0] q_hi [DEPTH];
  logic [63:0] q_lo [DEPTH];
  logic [63:0] q_pl [DEPTH];
  logic        q_rsv [DEPTH];
  int unsigned q_count;
  int unsigned q_cap;
  logic [31:0] q_drops;
  logic        q_busy;

  out_item_t pending_results [$];
  int        error_count;
  bit        calm_phase;

  // Known ids, so that the random part can hit duplicates.
  logic [63:0] seen_hi [$];
  logic [63:0] seen_lo [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void count_drop();
    if (q_drops != 32'hFFFF_FFFF) q_drops++;
  endfunction

  function automatic void remove_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < q_count; i++) begin
      q_hi[i] = q_hi[i + 1];
      q_lo[i] = q_lo[i + 1];
      q_pl[i] = q_pl[i + 1];
      q_rsv[i] = q_rsv[i + 1];
    end
    if (q_count > 0) q_count--;
  endfunction

  function automatic int unsigned oldest_free();
    for (int unsigned i = 0; i < q_count; i++)
      if (!q_rsv[i]) return i;
    return DEPTH;
  endfunction

  function automatic void push_result(logic [2:0] st, logic [63:0] hi,
                                      logic [63:0] lo, logic [63:0] pl,
                                      logic last);
    out_item_t r;
    r.status = st;
    r.out_id_high = hi;
    r.out_id_low = lo;
    r.out_payload = pl;
    r.last_of_run = last;
    r.dropped_count = q_drops;
    r.entry_count = q_count[4:0];
    r.batch_in_flight = q_busy;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < DEPTH; i++) q_rsv[i] = 1'b0;
    q_count = 0;
    q_cap = DEPTH;
    q_drops = '0;
    q_busy = 1'b0;
  endfunction

  function automatic void predict_queue(in_item_t it);
    logic [2:0] st;
    bit dup;
    int unsigned n, j, v, c;
    st = ST_DONE;
    case (it.op)
      OP_ENQ: begin
        dup = (it.id_high == '0 && it.id_low == '0);
        for (int unsigned i = 0; i < q_count; i++)
          if (q_hi[i] == it.id_high && q_lo[i] == it.id_low) dup = 1;
        if (dup) begin
          count_drop();
          st = ST_INVALID;
        end else begin
          st = ST_OK;
          if (q_count >= q_cap) begin
            v = oldest_free();
            if (v >= DEPTH) st = ST_NOSLOT;
            else remove_entry(v);
            count_drop();
          end
          if (st == ST_OK) begin
            q_hi[q_count] = it.id_high;
            q_lo[q_count] = it.id_low;
            q_pl[q_count] = it.payload;
            q_rsv[q_count] = 1'b0;
            q_count++;
          end
        end
      end
      OP_BEGIN: begin
        if (q_busy || it.amount == 0 || q_count == 0) begin
          push_result(ST_REFUSED, '0, '0, '0, 1'b1);
          return;
        end
        n = (32'(it.amount) < q_count) ? 32'(it.amount) : q_count;
        for (int unsigned i = 0; i < n; i++) q_rsv[i] = 1'b1;
        q_busy = 1'b1;
        for (int unsigned i = 0; i < n; i++)
          push_result(ST_OK, q_hi[i], q_lo[i], q_pl[i], i + 1 == n);
        return;
      end
      OP_COMPLETE: begin
        if (it.remove_reserved && q_busy) begin
          j = 0;
          for (int unsigned i = 0; i < q_count; i++)
            if (!q_rsv[i]) begin
              q_hi[j] = q_hi[i];
              q_lo[j] = q_lo[i];
              q_pl[j] = q_pl[i];
              j++;
            end
          q_count = j;
        end
        for (int i = 0; i < DEPTH; i++) q_rsv[i] = 1'b0;
        q_busy = 1'b0;
      end
      OP_RESET: begin
        for (int i = 0; i < DEPTH; i++) q_rsv[i] = 1'b0;
        q_count = 0;
        q_busy = 1'b0;
        q_drops = '0;
      end
      OP_SETCAP: begin
        c = 32'(it.amount);
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        q_cap = c;
        while (q_count > q_cap) begin
          v = oldest_free();
          if (v >= DEPTH) break;
          remove_entry(v);
          count_drop();
        end
      end
      default: st = ST_INVALID;
    endcase
    push_result(st, '0, '0, '0, 1'b1);
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, logic [63:0] hi,
                                         logic [63:0] lo, logic [63:0] pl,
                                         logic [15:0] amt, logic rem);
    in_item_t it;
    it.op = op;
    it.id_high = hi;
    it.id_low = lo;
    it.payload = pl;
    it.amount = amt;
    it.remove_reserved = rem;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Sends one item, with an optional burst of idle cycles beforehand.
  task automatic send_item(in_item_t it);
    if (!calm_phase && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stall bursts, checks each accepted result.
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want !== out_data) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          error_count++;
        end
      end
    end
  end

  // Directed table; entries with a typed expectation carry it in its own row.
  in_item_t  dir_items [N_DIRECTED];
  bit        dir_has_status [N_DIRECTED];
  logic [2:0] dir_status [N_DIRECTED];

  task automatic set_row(int idx, in_item_t it, bit has, logic [2:0] st);
    dir_items[idx] = it;
    dir_has_status[idx] = has;
    dir_status[idx] = st;
  endtask

  initial begin
    in_item_t it;
    int r;
    logic [2:0] opc;
    error_count = 0;
    calm_phase = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    clear_shadow();

    set_row(0, make_item(OP_BEGIN, '0, '0, '0, 16'd5, 1'b0), 1'b1, ST_REFUSED);
    set_row(1, make_item(OP_ENQ, '0, '0, 64'h1234, '0, 1'b0), 1'b1, ST_INVALID);
    set_row(2, make_item(OP_ENQ, '1, '1, '1, '1, 1'b1), 1'b1, ST_OK);
    set_row(3, make_item(OP_ENQ, '1, '1, '0, '0, 1'b0), 1'b1, ST_INVALID);
    set_row(4, make_item(OP_ENQ, '0, 64'd1, 64'd7, '0, 1'b0), 1'b1, ST_OK);
    set_row(5, make_item(OP_ENQ, 64'd1, '0, 64'd8, '0, 1'b0), 1'b1, ST_OK);
    set_row(6, make_item(OP_COMPLETE, '0, '0, '0, '0, 1'b1), 1'b1, ST_DONE);
    set_row(7, make_item(OP_BEGIN, '0, '0, '0, 16'd0, 1'b0), 1'b1, ST_REFUSED);
    set_row(8, make_item(OP_BEGIN, '0, '0, '0, 16'd2, 1'b0), 1'b0, ST_OK);
    set_row(9, make_item(OP_BEGIN, '0, '0, '0, 16'd1, 1'b0), 1'b1, ST_REFUSED);
    set_row(10, make_item(OP_SETCAP, '0, '0, '0, 16'd0, 1'b0), 1'b1, ST_DONE);
    set_row(11, make_item(OP_ENQ, 64'd2, 64'd2, 64'd9, '0, 1'b0), 1'b1, ST_NOSLOT);
    set_row(12, make_item(OP_COMPLETE, '0, '0, '0, '0, 1'b0), 1'b1, ST_DONE);
    set_row(13, make_item(OP_ENQ, 64'd3, 64'd3, 64'd10, '0, 1'b0), 1'b0, ST_OK);
    set_row(14, make_item(OP_SETCAP, '0, '0, '0, 16'hFFFF, 1'b0), 1'b1, ST_DONE);
    set_row(15, make_item(3'd5, '0, '0, '0, '0, 1'b0), 1'b1, ST_INVALID);
    set_row(16, make_item(3'd7, '1, '1, '1, '1, 1'b1), 1'b1, ST_INVALID);
    set_row(17, make_item(OP_BEGIN, '0, '0, '0, 16'hFFFF, 1'b0), 1'b0, ST_OK);
    set_row(18, make_item(OP_COMPLETE, '0, '0, '0, '0, 1'b1), 1'b1, ST_DONE);
    set_row(19, make_item(OP_SETCAP, '0, '0, '0, 16'd16, 1'b0), 1'b1, ST_DONE);
    set_row(20, make_item(OP_RESET, '0, '0, '0, '0, 1'b0), 1'b1, ST_DONE);
    set_row(21, make_item(3'd6, '0, '0, '0, '0, 1'b0), 1'b1, ST_INVALID);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(dir_items[i]);
      // Typed-in status on rows where it is obvious; the full item is still
      // compared against the shadow copy.
      if (dir_has_status[i] && pending_results.size() != 0 &&
          pending_results[$].status !== dir_status[i]) begin
        $display("%0t: mismatch expected status %0d actual %0d", $time,
                 dir_status[i], pending_results[$].status);
        error_count++;
      end
    end

    wait_drained();

    // Random sequences: mostly enqueues with occasional batch traffic.
    for (int n = 0; n < 500; n++) begin
      if (n == 450) begin
        wait_drained();
        calm_phase = 1;
      end
      if (n == 200) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 55) opc = OP_ENQ;
      else if (r < 70) opc = OP_BEGIN;
      else if (r < 82) opc = OP_COMPLETE;
      else if (r < 93) opc = OP_SETCAP;
      else if (r < 96) opc = OP_RESET;
      else opc = 3'($urandom_range(5, 7));
      it = make_item(opc, rand64(), rand64(), rand64(), 16'($urandom()),
                     1'($urandom()));
      if (opc == OP_ENQ) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          it.id_high = '0;
          it.id_low = '0;
        end else if (r < 3 && seen_hi.size() != 0) begin
          r = $urandom_range(0, seen_hi.size() - 1);
          it.id_high = seen_hi[r];
          it.id_low = seen_lo[r];
        end else if (r < 5) begin
          it.id_high = 64'($urandom_range(0, 3));
          it.id_low = 64'($urandom_range(0, 7));
        end
        seen_hi.push_back(it.id_high);
        seen_lo.push_back(it.id_low);
        if (seen_hi.size() > 40) begin
          void'(seen_hi.pop_front());
          void'(seen_lo.pop_front());
        end
      end else if (opc == OP_BEGIN) begin
        if ($urandom_range(0, 7) != 0) it.amount = 16'($urandom_range(1, 20));
      end else if (opc == OP_SETCAP) begin
        if ($urandom_range(0, 7) != 0) it.amount = 16'($urandom_range(0, 18));
      end
      send_item(it);
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== dedup_retry_batch_queue.f =====
design/drbq_pkg.sv
design/dedup_retry_batch_queue.sv
dv/tb_dedup_retry_batch_queue.sv
